### design/chkt_pkg.sv
package chkt_pkg;

    // Default geometry
    localparam int MAX_BUCKETS_DEF  = 256;
    localparam int POOL_ENTRIES_DEF = 1024;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 31;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;
    localparam int CFG_W    = 9;

    // Bucket remainder divider: DIV_BITS dividend bits per cycle
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = 8;
    localparam int DIV_W     = DIV_BITS * DIV_STEPS;
    localparam int DCW       = $clog2(DIV_STEPS);

    // Operation codes; the spare code behaves as a lookup
    localparam logic [KIND_W-1:0] KIND_INSERT     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LOOKUP_ALT = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOCHANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic in_ready;
        logic clr_step;
        logic div_step;
        logic head_rd;
        logic walk_load;
        logic walk_rd;
        logic walk_adv;
        logic hit_set;
        logic act;
        logic free_rd;
        logic ins_a;
        logic ins_b;
        logic rem_wr;
        logic res_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_beat;
        logic cfg_beat;
        logic clr_last;
        logic div_last;
        logic cur_none;
        logic key_match;
        logic hit;
        logic full;
        logic kind_ins;
        logic kind_rem;
        logic tail_none;
        logic out_free;
    } t_sts;

endpackage

### design/chkt_in_if.sv
interface chkt_in_if import chkt_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [KEY_W-1:0]    key;
    logic [VAL_W-1:0]    entry_value;

    modport source (output valid, kind, key, entry_value, input ready);
    modport sink   (input valid, kind, key, entry_value, output ready);
endinterface

### design/chkt_out_if.sv
interface chkt_out_if import chkt_pkg::*;;
    logic                valid;
    logic                ready;
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, found, status, entry_count, input ready);
    modport sink   (input valid, found, status, entry_count, output ready);
endinterface

### design/chkt_cfg_if.sv
interface chkt_cfg_if import chkt_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] num_buckets;

    modport source (output valid, num_buckets, input ready);
    modport sink   (input valid, num_buckets, output ready);
endinterface

### design/chkt_ram.sv
module chkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, registered read port that holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### design/chkt_ctrl.sv
module chkt_ctrl import chkt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_DIV   = 13'b0000000000100,
        S_HEAD  = 13'b0000000001000,
        S_HWAIT = 13'b0000000010000,
        S_WRD   = 13'b0000000100000,
        S_WCMP  = 13'b0000001000000,
        S_ACT   = 13'b0000010000000,
        S_FREE  = 13'b0000100000000,
        S_INS_A = 13'b0001000000000,
        S_INS_B = 13'b0010000000000,
        S_REM   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_beat) n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.head_rd = 1'b1;
                n_state = S_HWAIT;
            end
            S_HWAIT: begin
                o_cmd.walk_load = 1'b1;
                n_state = S_WRD;
            end
            S_WRD: begin
                if (i_sts.cur_none) begin
                    n_state = S_ACT;
                end else begin
                    o_cmd.walk_rd = 1'b1;
                    n_state = S_WCMP;
                end
            end
            S_WCMP: begin
                if (i_sts.key_match) begin
                    o_cmd.hit_set = 1'b1;
                    n_state = S_ACT;
                end else begin
                    o_cmd.walk_adv = 1'b1;
                    n_state = S_WRD;
                end
            end
            S_ACT: begin
                o_cmd.act = 1'b1;
                if (i_sts.kind_ins && !i_sts.hit && !i_sts.full) begin
                    o_cmd.free_rd = 1'b1;
                    n_state = S_FREE;
                end else if (i_sts.kind_rem && i_sts.hit) begin
                    n_state = S_REM;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FREE: begin
                n_state = S_INS_A;
            end
            S_INS_A: begin
                o_cmd.ins_a = 1'b1;
                n_state = i_sts.tail_none ? S_DONE : S_INS_B;
            end
            S_INS_B: begin
                o_cmd.ins_b = 1'b1;
                n_state = S_DONE;
            end
            S_REM: begin
                o_cmd.rem_wr = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        // A bucket count write restarts the clearing pass
        if (i_sts.cfg_beat) n_state = S_CLEAR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

### design/chkt_dp.sv
module chkt_dp import chkt_pkg::*; #(
    parameter int MAX_BUCKETS  = MAX_BUCKETS_DEF,
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chkt_in_if.sink     i_in,
    chkt_out_if.source  o_out,
    chkt_cfg_if.sink    i_cfg,
    input  t_cmd        i_cmd,
    output t_sts        o_sts
);
    localparam int PW  = $clog2(POOL_ENTRIES);
    localparam int IW  = PW + 1;
    localparam int CW  = $clog2(POOL_ENTRIES + 1);
    localparam int NBW = $clog2(MAX_BUCKETS + 1);
    localparam int BAW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CLN = (MAX_BUCKETS > POOL_ENTRIES) ? MAX_BUCKETS : POOL_ENTRIES;
    localparam int CLW = $clog2(CLN);
    localparam logic [IW-1:0] NONE = IW'(POOL_ENTRIES);

    // Control registers
    logic [NBW-1:0]      r_nb;
    logic [CW-1:0]       r_cnt;
    logic [CLW-1:0]      r_clr;
    logic                r_ovalid;

    // Payload registers
    logic [KIND_W-1:0]   r_kind;
    logic [KEY_W-1:0]    r_key;
    logic [VAL_W-1:0]    r_val;
    logic [DIV_W-1:0]    r_dvd;
    logic [NBW-1:0]      r_rem;
    logic [DCW-1:0]      r_dcnt;
    logic [IW-1:0]       r_cur;
    logic [IW-1:0]       r_prev;
    logic                r_hit;
    logic [STATUS_W-1:0] r_status;
    logic                r_found;
    logic [STATUS_W-1:0] r_ostatus;
    logic [COUNT_W-1:0]  r_ocnt;

    logic                in_beat;
    logic                cfg_beat;
    logic                out_beat;
    logic [NBW-1:0]      nb_cfg;
    logic [NBW:0]        div_t;
    logic [NBW-1:0]      n_rem;
    logic [BAW-1:0]      bucket;
    logic [PW-1:0]       e_idx;
    logic                prev_none;
    logic [CW+COUNT_W-1:0] cnt_ext;

    // RAM ports
    logic                head_we;
    logic [BAW-1:0]      head_waddr;
    logic [IW-1:0]       head_wdata;
    logic [IW-1:0]       head_rdata;
    logic [KEY_W-1:0]    key_rdata;
    logic                link_we;
    logic [PW-1:0]       link_waddr;
    logic [IW-1:0]       link_wdata;
    logic [IW-1:0]       link_rdata;
    logic                free_we;
    logic [PW-1:0]       free_waddr;
    logic [PW-1:0]       free_wdata;
    logic [PW-1:0]       free_raddr;
    logic [PW-1:0]       free_rdata;

    assign in_beat   = i_in.valid & i_in.ready;
    assign cfg_beat  = i_cfg.valid & i_cfg.ready;
    assign out_beat  = o_out.valid & o_out.ready;
    assign i_in.ready  = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    assign bucket    = BAW'(r_rem);
    assign e_idx     = free_rdata;
    assign prev_none = (r_prev == NONE);
    assign cnt_ext   = {{COUNT_W{1'b0}}, r_cnt};

    // Clamp the written bucket count into 1..MAX_BUCKETS
    always_comb begin
        if (i_cfg.num_buckets == '0) begin
            nb_cfg = NBW'(1);
        end else if (int'(i_cfg.num_buckets) > MAX_BUCKETS) begin
            nb_cfg = NBW'(MAX_BUCKETS);
        end else begin
            nb_cfg = NBW'(i_cfg.num_buckets);
        end
    end

    // Restoring remainder, DIV_BITS dividend bits per cycle
    always_comb begin
        n_rem = r_rem;
        div_t = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            div_t = {n_rem, r_dvd[DIV_W-1-i]};
            if (div_t >= {1'b0, r_nb}) div_t = div_t - {1'b0, r_nb};
            n_rem = div_t[NBW-1:0];
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.in_beat   = in_beat;
        o_sts.cfg_beat  = cfg_beat;
        o_sts.clr_last  = (r_clr == CLW'(CLN - 1));
        o_sts.div_last  = (r_dcnt == DCW'(DIV_STEPS - 1));
        o_sts.cur_none  = (r_cur == NONE);
        o_sts.key_match = (key_rdata == r_key);
        o_sts.hit       = r_hit;
        o_sts.full      = (r_cnt == CW'(POOL_ENTRIES));
        o_sts.kind_ins  = (r_kind == KIND_INSERT);
        o_sts.kind_rem  = (r_kind == KIND_REMOVE);
        o_sts.tail_none = prev_none;
        o_sts.out_free  = !r_ovalid || o_out.ready;
    end

    // Bucket heads: cleared by the sweep, relinked on insert and remove
    always_comb begin
        head_we    = (i_cmd.clr_step && (int'(r_clr) < MAX_BUCKETS))
                   || (i_cmd.ins_a && prev_none)
                   || (i_cmd.rem_wr && prev_none);
        head_waddr = i_cmd.clr_step ? BAW'(r_clr) : bucket;
        if (i_cmd.clr_step) begin
            head_wdata = NONE;
        end else if (i_cmd.ins_a) begin
            head_wdata = {1'b0, e_idx};
        end else begin
            head_wdata = link_rdata;
        end
    end

    // Chain links: terminate the new entry, hook it to the tail, bypass a removed one
    always_comb begin
        link_we    = i_cmd.ins_a || i_cmd.ins_b || (i_cmd.rem_wr && !prev_none);
        link_waddr = i_cmd.ins_a ? e_idx : r_prev[PW-1:0];
        if (i_cmd.ins_a) begin
            link_wdata = NONE;
        end else if (i_cmd.ins_b) begin
            link_wdata = {1'b0, e_idx};
        end else begin
            link_wdata = link_rdata;
        end
    end

    // Free stack: filled by the sweep, popped on insert, pushed on remove
    always_comb begin
        free_we    = (i_cmd.clr_step && (int'(r_clr) < POOL_ENTRIES)) || i_cmd.rem_wr;
        free_waddr = i_cmd.clr_step ? PW'(r_clr) : PW'(CW'(POOL_ENTRIES) - r_cnt);
        free_wdata = i_cmd.clr_step ? PW'(r_clr) : r_cur[PW-1:0];
        free_raddr = PW'(CW'(POOL_ENTRIES - 1) - r_cnt);
    end

    chkt_ram #(.WIDTH(IW), .DEPTH(MAX_BUCKETS)) u_head (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_re    (i_cmd.head_rd),
        .i_raddr (bucket),
        .o_rdata (head_rdata)
    );

    chkt_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES)) u_key (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_a),
        .i_waddr (e_idx),
        .i_wdata (r_key),
        .i_re    (i_cmd.walk_rd),
        .i_raddr (r_cur[PW-1:0]),
        .o_rdata (key_rdata)
    );

    chkt_ram #(.WIDTH(VAL_W), .DEPTH(POOL_ENTRIES)) u_data (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_a),
        .i_waddr (e_idx),
        .i_wdata (r_val),
        .i_re    (1'b0),
        .i_raddr (r_cur[PW-1:0]),
        .o_rdata ()
    );

    chkt_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (i_cmd.walk_rd),
        .i_raddr (r_cur[PW-1:0]),
        .o_rdata (link_rdata)
    );

    chkt_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_free (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (free_waddr),
        .i_wdata (free_wdata),
        .i_re    (i_cmd.free_rd),
        .i_raddr (free_raddr),
        .o_rdata (free_rdata)
    );

    // Control state: bucket count, entry count, sweep counter, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb     <= NBW'(MAX_BUCKETS);
            r_cnt    <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (cfg_beat) begin
                r_nb  <= nb_cfg;
                r_cnt <= '0;
                r_clr <= '0;
            end else begin
                if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
                if (i_cmd.ins_a)    r_cnt <= r_cnt + 1'b1;
                if (i_cmd.rem_wr)   r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.res_load) begin
                r_ovalid <= 1'b1;
            end else if (out_beat) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Operation payload, divider and chain walk
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_kind <= i_in.kind;
            r_key  <= i_in.key;
            r_val  <= i_in.entry_value;
            r_dvd  <= DIV_W'(i_in.key);
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd  <= r_dvd << DIV_BITS;
            r_rem  <= n_rem;
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.walk_load) begin
            r_cur  <= head_rdata;
            r_prev <= NONE;
            r_hit  <= 1'b0;
        end
        if (i_cmd.walk_adv) begin
            r_prev <= r_cur;
            r_cur  <= link_rdata;
        end
        if (i_cmd.hit_set) r_hit <= 1'b1;
        if (i_cmd.act) begin
            if (r_kind == KIND_INSERT) begin
                if (r_hit) begin
                    r_status <= ST_NOCHANGE;
                end else if (r_cnt == CW'(POOL_ENTRIES)) begin
                    r_status <= ST_FULL;
                end else begin
                    r_status <= ST_DONE;
                end
            end else begin
                r_status <= r_hit ? ST_DONE : ST_NOCHANGE;
            end
        end
        if (i_cmd.res_load) begin
            r_found   <= r_hit;
            r_ostatus <= r_status;
            r_ocnt    <= cnt_ext[COUNT_W-1:0];
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.found       = r_found;
    assign o_out.status      = r_ostatus;
    assign o_out.entry_count = r_ocnt;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(POOL_ENTRIES))
        else $error("entry count beyond pool size");

    a_res_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> (!r_ovalid || o_out.ready))
        else $error("result loaded over an untaken result");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ins_a && !cfg_beat) |=> r_cnt == CW'($past(r_cnt) + 1'b1))
        else $error("insert did not advance entry count");

    a_bucket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.head_rd |-> r_rem < r_nb)
        else $error("bucket index not below bucket count");
endmodule

### design/chained_hash_key_table.sv
// Hash table of up to POOL_ENTRIES keys (31-bit) with a 64-bit value each, chained per
// bucket; the bucket is key mod num_buckets, which is clamped into 1..MAX_BUCKETS. After
// reset and after every write of num_buckets the table runs a clearing pass over
// max(MAX_BUCKETS, POOL_ENTRIES) entries (1024 by default) and takes no operation
// meanwhile. One operation goes from its input beat through acceptance, the
// 4-bit-per-cycle remainder unit, the bucket head read, the registered key and link
// memory reads for each compared entry, a check for the end of the chain on a miss, the
// decision, the update (free stack read, entry write, tail link) and the loading of the
// result. A result that is not taken holds the next result back. Operations run one at a
// time; the next is accepted while a result waits.
module chained_hash_key_table import chkt_pkg::*; #(
    parameter int MAX_BUCKETS  = MAX_BUCKETS_DEF,
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chkt_in_if.sink     i_in,
    chkt_out_if.source  o_out,
    chkt_cfg_if.sink    i_cfg
);
    t_cmd cmd;
    t_sts sts;

    chkt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    chkt_dp #(
        .MAX_BUCKETS  (MAX_BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );
endmodule

### tb/chained_hash_key_table_test.sv
`timescale 1ns / 1ps

module chained_hash_key_table_test;
    import chkt_pkg::*;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  entry_value;
    } t_op;

    typedef struct {
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
    } t_reply;

    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;

    chkt_in_if  in_bus();
    chkt_out_if out_bus();
    chkt_cfg_if cfg_bus();

    chained_hash_key_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus.sink),
        .o_out   (out_bus.source),
        .i_cfg   (cfg_bus.sink)
    );

    // Shadow table: key presence and the count of stored entries
    bit          key_present [logic [KEY_W-1:0]];
    int unsigned stored_entries;

    t_op    pending_ops[$];
    t_reply expected_replies[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_ops;
    int  errors;
    int  ops_accepted;
    int  replies_checked;
    int  cycles;
    logic [KEY_W-1:0] key_set[$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Work out the reply of one operation and advance the shadow table
    function automatic t_reply apply_op(t_op op);
        t_reply r;
        logic   hit;
        hit = key_present.exists(op.key);
        r.found = hit;
        case (op.kind)
            KIND_INSERT: begin
                if (hit) begin
                    r.status = ST_NOCHANGE;
                end else if (stored_entries >= POOL_ENTRIES_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    key_present[op.key] = 1'b1;
                    stored_entries++;
                    r.status = ST_DONE;
                end
            end
            KIND_REMOVE: begin
                if (hit) begin
                    key_present.delete(op.key);
                    stored_entries--;
                    r.status = ST_DONE;
                end else begin
                    r.status = ST_NOCHANGE;
                end
            end
            default: r.status = hit ? ST_DONE : ST_NOCHANGE;
        endcase
        r.entry_count = stored_entries[COUNT_W-1:0];
        return r;
    endfunction

    // Driver: predict on each accepted beat, then present the next operation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid       <= 1'b0;
            in_bus.kind        <= KIND_INSERT;
            in_bus.key         <= '0;
            in_bus.entry_value <= '0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                expected_replies.push_back(apply_op('{in_bus.kind, in_bus.key,
                                                      in_bus.entry_value}));
                ops_accepted++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_ops.size() != 0 && !hold_ops &&
                    $urandom_range(99) >= send_idle_pct) begin
                    t_op op;
                    op = pending_ops.pop_front();
                    in_bus.valid       <= 1'b1;
                    in_bus.kind        <= op.kind;
                    in_bus.key         <= op.key;
                    in_bus.entry_value <= op.entry_value;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random and compare each reply beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (out_bus.valid && out_bus.ready) begin
                if (expected_replies.size() == 0) begin
                    $error("unexpected reply beat");
                    errors++;
                end else begin
                    t_reply e;
                    e = expected_replies.pop_front();
                    replies_checked++;
                    if (out_bus.found !== e.found) begin
                        $error("found: expected %0d, got %0d", e.found, out_bus.found);
                        errors++;
                    end
                    if (out_bus.status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, out_bus.status);
                        errors++;
                    end
                    if (out_bus.entry_count !== e.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               e.entry_count, out_bus.entry_count);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("chained_hash_key_table_test: FAIL");
            $finish;
        end
    end

    task automatic push_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                           logic [VAL_W-1:0] val);
        pending_ops.push_back('{kind, key, val});
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    // Wait until every queued operation has been answered
    task automatic drain();
        do @(posedge i_clk);
        while (pending_ops.size() != 0 || expected_replies.size() != 0 || in_bus.valid);
    endtask

    // Write the bucket count; the table clears, so does the shadow
    task automatic write_buckets(logic [CFG_W-1:0] nb);
        @(posedge i_clk);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.num_buckets <= nb;
        do @(posedge i_clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        key_present.delete();
        stored_entries = 0;
    endtask

    // Random mix over a small set of full-width keys so hits are common
    task automatic random_ops(int n, int set_size);
        logic [KIND_W-1:0] k;
        key_set.delete();
        for (int i = 0; i < set_size; i++) key_set.push_back(KEY_W'($urandom));
        for (int i = 0; i < n; i++) begin
            k = ($urandom_range(99) < 45) ? KIND_INSERT : KIND_W'($urandom_range(3));
            push_op(k, key_set[$urandom_range(set_size - 1)], rand_value());
        end
    endtask

    initial begin
        logic [KEY_W-1:0] kmax;
        kmax = '1;
        i_rst_n             = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.num_buckets = '0;
        hold_ops            = 1'b0;
        send_idle_pct       = 13;
        recv_idle_pct       = 60;
        errors              = 0;
        ops_accepted        = 0;
        replies_checked     = 0;
        cycles              = 0;
        stored_entries      = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, chain collisions, every operation code and the done and no-change statuses
        push_op(KIND_INSERT, '0, '0);
        push_op(KIND_INSERT, kmax, '1);
        push_op(KIND_INSERT, kmax, 64'h1234);
        push_op(KIND_LOOKUP, kmax, '0);
        push_op(KIND_LOOKUP, 31'd5, '0);
        push_op(KIND_LOOKUP_ALT, '0, '0);
        push_op(KIND_LOOKUP_ALT, 31'd7, '0);
        push_op(KIND_INSERT, 31'd256, rand_value());
        push_op(KIND_INSERT, 31'd512, rand_value());
        push_op(KIND_INSERT, 31'd768, rand_value());
        push_op(KIND_REMOVE, 31'd256, '0);
        push_op(KIND_LOOKUP, 31'd512, '0);
        push_op(KIND_REMOVE, '0, '0);
        push_op(KIND_LOOKUP, 31'd768, '0);
        push_op(KIND_REMOVE, 31'd768, '0);
        push_op(KIND_REMOVE, 31'd768, '0);
        push_op(KIND_REMOVE, kmax, '0);
        push_op(KIND_LOOKUP, kmax, '0);
        push_op(KIND_INSERT, 31'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        push_op(KIND_INSERT, 31'h2AAA_AAAA, 64'h5555_5555_5555_5555);
        drain();

        // Zero bucket count acts as one bucket: a single long chain
        write_buckets('0);
        random_ops(80, 16);
        drain();

        send_idle_pct = 60;
        recv_idle_pct = 13;
        write_buckets(9'd7);
        random_ops(60, 24);
        // Send part of the batch, hold the sender until everything is answered, then go on
        hold_ops = 1'b0;
        do @(posedge i_clk);
        while (pending_ops.size() > 50);
        hold_ops = 1'b1;
        do @(posedge i_clk);
        while (expected_replies.size() != 0 || in_bus.valid);
        hold_ops = 1'b0;
        drain();

        write_buckets(9'd1);
        random_ops(40, 12);
        drain();

        // Oversized count saturates; fill the pool and run into it full
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_buckets(9'd511);
        for (int i = 0; i < POOL_ENTRIES_DEF; i++)
            push_op(KIND_INSERT, KEY_W'((i << 21) ^ ($urandom & 32'h001F_FFFF)),
                    rand_value());
        push_op(KIND_INSERT, 31'h7000_0001, rand_value());
        push_op(KIND_INSERT, kmax, rand_value());
        push_op(KIND_LOOKUP, kmax, '0);
        random_ops(20, 8);
        drain();

        write_buckets(9'd256);
        random_ops(40, 40);
        drain();
        repeat (100) @(posedge i_clk);

        $display("Covered %0d operations and %0d replies over bucket counts 0, 7, 1, 511, 256,",
                 ops_accepted, replies_checked);
        $display("including chain collisions, a full pool and every operation code.");
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("chained_hash_key_table_test: PASS");
        end else begin
            $display("chained_hash_key_table_test: FAIL");
        end
        $finish;
    end

endmodule
